### rtl/brdec_pkg.sv
`timescale 1ns / 1ps

package brdec_pkg;

   // Width of the decoded-byte field of a result word, in bytes.
   localparam int OUT_BYTES  = 4;
   // Requested repeat beat width; a beat never carries more than OUT_BYTES.
   localparam int BEAT_BYTES = 4;
   localparam int BEAT_MAX   = (BEAT_BYTES > OUT_BYTES) ? OUT_BYTES :
                               ((BEAT_BYTES < 1) ? 1 : BEAT_BYTES);

   localparam int SIZE_W  = 25;
   localparam int COUNT_W = 3;
   localparam int STAT_W  = 3;
   localparam int RUN_W   = 7;
   localparam int NREP_W  = 8;

   localparam logic [7:0] SKIP_CODE = 8'h80;

   // Decoder phases.
   localparam logic [1:0] PH_CONTROL = 2'd0;
   localparam logic [1:0] PH_LITERAL = 2'd1;
   localparam logic [1:0] PH_REPEAT  = 2'd2;
   localparam logic [1:0] PH_DISCARD = 2'd3;

   // Status codes.
   localparam logic [STAT_W-1:0] ST_RUNNING   = 3'd0;
   localparam logic [STAT_W-1:0] ST_COMPLETE  = 3'd1;
   localparam logic [STAT_W-1:0] ST_TRUNCATED = 3'd2;
   localparam logic [STAT_W-1:0] ST_EXPANDS   = 3'd3;
   localparam logic [STAT_W-1:0] ST_TRAILING  = 3'd4;

   typedef struct packed {
      logic [STAT_W-1:0]      status;
      logic [COUNT_W-1:0]     byte_count;
      logic [8*OUT_BYTES-1:0] out_bytes;
      logic                   last_result;
   } rsp_word_type;

endpackage

### rtl/byterun1_run_length_decoder_unit.sv
`timescale 1ns / 1ps
// A control or literal byte is decoded in the accept cycle and its result word, if any,
// appears on the next cycle; a discarded byte gives no word. A repeat payload sends its emitted
// run (up to 128 bytes) as beats of up to four bytes; a run with nothing left to emit still
// sends one status word. One beat leaves per cycle while rsp_tready does not stall it.
// Throughput: one word per cycle outside repeat runs unless stalled; input waits while beats drain.
// Reset (synchronous, active high) clears the size register, the decoder phase and the run and produced-byte counters.
module byterun1_run_length_decoder_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_wr_en,
   input  logic [brdec_pkg::SIZE_W-1:0]            csr_wr_data,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [7:0]                              req_tdata,  // data_byte [7:0]
   input  logic                                    req_tlast,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [39:0]                             rsp_tdata,  // out_bytes [31:0], byte_count [34:32]
   output logic [brdec_pkg::STAT_W-1:0]            rsp_tuser,  // status [2:0]
   output logic                                    rsp_tlast
);

   localparam logic SEQ_IDLE = 1'b0;
   localparam logic SEQ_BEAT = 1'b1;

   logic                              seq_ff, seq_in;
   logic [1:0]                        phase_ff, phase_in;
   logic [brdec_pkg::RUN_W-1:0]       run_rem_ff, run_rem_in;
   logic [brdec_pkg::SIZE_W-1:0]      produced_ff, produced_in;
   logic                              ovf_ff, ovf_in;
   logic [brdec_pkg::SIZE_W-1:0]      expected_ff;
   logic [brdec_pkg::NREP_W-1:0]      nrep_ff, nrep_in;
   logic [7:0]                        rep_byte_ff, rep_byte_in;
   logic [brdec_pkg::STAT_W-1:0]      rep_st_ff, rep_st_in;
   logic                              rep_last_ff, rep_last_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   brdec_pkg::rsp_word_type           rsp_ff, rsp_in;

   logic                              out_free;
   logic                              accept;
   logic [brdec_pkg::SIZE_W:0]        diff;
   logic                              reached;
   logic [brdec_pkg::SIZE_W-1:0]      room;
   logic [brdec_pkg::NREP_W-1:0]      rep_count;
   logic                              room_lt_count;
   logic                              room_le_count;
   logic                              ovf_new;
   logic [brdec_pkg::STAT_W-1:0]      acc_st;
   logic                              acc_emit;
   logic                              rearm;
   logic [brdec_pkg::COUNT_W-1:0]     beat_c;
   logic                              beat_final;
   logic [8*brdec_pkg::OUT_BYTES-1:0] beat_word;
   logic [7:0]                        neg_byte;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (seq_ff == SEQ_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;

   // Subtractor for the remaining room: produced count against the expected size.
   assign diff          = {1'b0, expected_ff} - {1'b0, produced_ff};
   assign reached       = diff[brdec_pkg::SIZE_W] || (diff[brdec_pkg::SIZE_W-1:0] == '0);
   assign room          = reached ? '0 : diff[brdec_pkg::SIZE_W-1:0];
   assign rep_count     = {1'b0, run_rem_ff} + 8'd1;
   assign room_lt_count = room < brdec_pkg::SIZE_W'(rep_count);
   assign room_le_count = room <= brdec_pkg::SIZE_W'(rep_count);
   assign neg_byte      = 8'd0 - req_tdata;

   assign beat_final = nrep_ff <= brdec_pkg::NREP_W'(brdec_pkg::BEAT_MAX);
   assign beat_c     = beat_final ? nrep_ff[brdec_pkg::COUNT_W-1:0]
                                  : brdec_pkg::COUNT_W'(brdec_pkg::BEAT_MAX);

   always_comb begin
      beat_word = '0;
      for (int i = 0; i < brdec_pkg::OUT_BYTES; i++) begin
         if (brdec_pkg::COUNT_W'(i) < beat_c) begin
            beat_word[8*i +: 8] = rep_byte_ff;
         end
      end
   end

   always_comb begin
      seq_in       = seq_ff;
      phase_in     = phase_ff;
      run_rem_in   = run_rem_ff;
      produced_in  = produced_ff;
      ovf_in       = ovf_ff;
      nrep_in      = nrep_ff;
      rep_byte_in  = rep_byte_ff;
      rep_st_in    = rep_st_ff;
      rep_last_in  = rep_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      acc_st       = brdec_pkg::ST_RUNNING;
      acc_emit     = 1'b0;
      ovf_new      = ovf_ff;
      rearm        = 1'b0;

      case (seq_ff)
         SEQ_IDLE: begin
            if (accept) begin
               case (phase_ff)
                  brdec_pkg::PH_DISCARD: begin
                     rearm = req_tlast;
                  end
                  brdec_pkg::PH_CONTROL: begin
                     if (reached) begin
                        acc_st = brdec_pkg::ST_TRAILING;
                     end else if (req_tdata < brdec_pkg::SKIP_CODE) begin
                        run_rem_in = req_tdata[brdec_pkg::RUN_W-1:0];
                        phase_in   = brdec_pkg::PH_LITERAL;
                     end else if (req_tdata != brdec_pkg::SKIP_CODE) begin
                        run_rem_in = neg_byte[brdec_pkg::RUN_W-1:0];
                        phase_in   = brdec_pkg::PH_REPEAT;
                     end
                     if (!reached && req_tlast) begin
                        acc_st = brdec_pkg::ST_TRUNCATED;
                     end
                  end
                  brdec_pkg::PH_LITERAL: begin
                     acc_emit = !reached;
                     if (reached) begin
                        ovf_new = 1'b1;
                     end else begin
                        produced_in = produced_ff + brdec_pkg::SIZE_W'(1);
                     end
                     ovf_in = ovf_new;
                     if (run_rem_ff == '0) begin
                        phase_in = brdec_pkg::PH_CONTROL;
                        // The size is met after this byte if it was already met or
                        // this byte filled the last free place.
                        if (ovf_new) begin
                           acc_st = brdec_pkg::ST_EXPANDS;
                        end else if (diff == (brdec_pkg::SIZE_W+1)'(1)) begin
                           acc_st = req_tlast ? brdec_pkg::ST_COMPLETE
                                              : brdec_pkg::ST_TRAILING;
                        end else if (req_tlast) begin
                           acc_st = brdec_pkg::ST_TRUNCATED;
                        end
                     end else begin
                        run_rem_in = run_rem_ff - brdec_pkg::RUN_W'(1);
                        if (req_tlast) begin
                           acc_st = brdec_pkg::ST_TRUNCATED;
                        end
                     end
                  end
                  default: begin
                     // Repeat payload: size the run now, emit it beat by beat.
                     ovf_new     = ovf_ff || room_lt_count;
                     ovf_in      = ovf_new;
                     nrep_in     = room_lt_count ? room[brdec_pkg::NREP_W-1:0] : rep_count;
                     rep_byte_in = req_tdata;
                     rep_last_in = req_tlast;
                     run_rem_in  = '0;
                     phase_in    = brdec_pkg::PH_CONTROL;
                     seq_in      = SEQ_BEAT;
                     if (ovf_new) begin
                        rep_st_in = brdec_pkg::ST_EXPANDS;
                     end else if (reached || room_le_count) begin
                        rep_st_in = req_tlast ? brdec_pkg::ST_COMPLETE
                                              : brdec_pkg::ST_TRAILING;
                     end else begin
                        rep_st_in = req_tlast ? brdec_pkg::ST_TRUNCATED
                                              : brdec_pkg::ST_RUNNING;
                     end
                  end
               endcase

               if (phase_ff == brdec_pkg::PH_CONTROL || phase_ff == brdec_pkg::PH_LITERAL) begin
                  if (acc_emit || acc_st != brdec_pkg::ST_RUNNING) begin
                     rsp_valid_in           = 1'b1;
                     rsp_in.out_bytes       = acc_emit ? {24'd0, req_tdata} : '0;
                     rsp_in.byte_count      = acc_emit ? 3'd1 : 3'd0;
                     rsp_in.status          = acc_st;
                     rsp_in.last_result     = 1'b1;
                  end
                  if (acc_st != brdec_pkg::ST_RUNNING) begin
                     if (req_tlast) begin
                        rearm = 1'b1;
                     end else begin
                        phase_in = brdec_pkg::PH_DISCARD;
                     end
                  end
               end
            end
         end
         default: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.out_bytes   = beat_word;
               rsp_in.byte_count  = beat_c;
               rsp_in.status      = beat_final ? rep_st_ff : brdec_pkg::ST_RUNNING;
               rsp_in.last_result = beat_final;
               produced_in        = produced_ff + brdec_pkg::SIZE_W'(beat_c);
               nrep_in            = nrep_ff - brdec_pkg::NREP_W'(beat_c);
               if (beat_final) begin
                  seq_in = SEQ_IDLE;
                  if (rep_st_ff != brdec_pkg::ST_RUNNING) begin
                     if (rep_last_ff) begin
                        rearm = 1'b1;
                     end else begin
                        phase_in = brdec_pkg::PH_DISCARD;
                     end
                  end
               end
            end
         end
      endcase

      if (rearm) begin
         phase_in    = brdec_pkg::PH_CONTROL;
         run_rem_in  = '0;
         produced_in = '0;
         ovf_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_IDLE;
         phase_ff     <= brdec_pkg::PH_CONTROL;
         run_rem_ff   <= '0;
         produced_ff  <= '0;
         ovf_ff       <= 1'b0;
         expected_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         phase_ff     <= phase_in;
         run_rem_ff   <= run_rem_in;
         produced_ff  <= produced_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            expected_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      nrep_ff     <= nrep_in;
      rep_byte_ff <= rep_byte_in;
      rep_st_ff   <= rep_st_in;
      rep_last_ff <= rep_last_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff.byte_count, rsp_ff.out_bytes};
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tlast  = rsp_ff.last_result;

endmodule
